/* hdl/bsrc_pkg.sv */
// Shared types and constants for the bank-switched RAM card.
package bsrc_pkg;

    // Sizes of the three RAM regions, in bytes.
    localparam int BankBytes  = 4096;
    localparam int UpperBytes = 8192;
    localparam int MemBytes   = 2 * BankBytes + UpperBytes;

    localparam int AddrW      = 14;
    localparam int DataW      = 8;
    localparam int BankIdxW   = $clog2(BankBytes);
    localparam int UpperIdxW  = $clog2(UpperBytes);
    localparam int MemIdxW    = $clog2(MemBytes);

    // Region offset where the upper RAM starts.
    localparam logic [UpperIdxW-1:0] LowerLimit = UpperIdxW'(BankBytes);

    // Access kinds carried in the func field.
    localparam logic FuncSwitch = 1'b0;
    localparam logic FuncMemory = 1'b1;

    // Odd-read counter saturates here and then enables writes.
    localparam logic [1:0] OddReadMax = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } bsrc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } bsrc_cmd_t;

endpackage

/* hdl/bank_switched_ram_card_top.sv */
// Top level of the bank-switched 16K RAM card.
//
// Input channel (in_valid / in_stall) carries one bus access per transaction:
// func selects a soft-switch access or a memory-region access, address is the
// switch address or the offset into the 12K region, write marks a write and
// data_in is the bus byte. Output channel (out_valid / out_stall) returns one
// result per transaction: data_out is the RAM byte on a served read and the
// bus byte otherwise, inhibit_rom is high when the card supplied the data.
// Each transaction is captured, then makes one access to the single-port RAM
// with its registered read, and then shows its result. The next transaction is
// taken once the result has been taken, so a new one cannot enter while one is
// in flight. While the receiver stalls, the result holds and the input stalls.
// Reset clears read enable, the odd-read counter and ROM inhibit, and sets
// write enable and bank 1; RAM contents are not cleared and a location must
// be written before it is read.
module bank_switched_ram_card_top
    import bsrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             func,
    input  logic [AddrW-1:0] address,
    input  logic             write,
    input  logic [DataW-1:0] data_in,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [DataW-1:0] data_out,
    output logic             inhibit_rom
);

    bsrc_cmd_t cmd;

    // Transaction sequencer.
    bsrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Switch latches, RAM and result.
    bsrc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .address     (address),
        .write       (write),
        .data_in     (data_in),
        .data_out    (data_out),
        .inhibit_rom (inhibit_rom)
    );

`ifndef SYNTHESIS
    // An accepted transaction blocks the input until its result is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in flight");

    // A taken result is never shown a second time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
    else $error("result repeated after it was taken");

    // A result only appears while the input side is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(in_stall) && in_stall))
    else $error("result appeared without a transaction in flight");
`endif

endmodule

/* hdl/bsrc_ctrl.sv */
// Controller state machine: sequences one transaction through the datapath.
module bsrc_ctrl
    import bsrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output bsrc_cmd_t cmd
);

    bsrc_state_t state_reg;
    bsrc_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command outputs.
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/bsrc_datapath.sv */
// Datapath: soft-switch latches, the 16K RAM and the result registers.
module bsrc_datapath
    import bsrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bsrc_cmd_t        cmd,
    input  logic             func,
    input  logic [AddrW-1:0] address,
    input  logic             write,
    input  logic [DataW-1:0] data_in,
    output logic [DataW-1:0] data_out,
    output logic             inhibit_rom
);

    // Captured transaction fields.
    logic             func_reg;
    logic [AddrW-1:0] addr_reg;
    logic             write_reg;
    logic [DataW-1:0] data_reg;

    // Soft-switch state.
    logic [1:0] odd_cnt_reg;
    logic [1:0] odd_cnt_next;
    logic       read_en_reg;
    logic       write_en_reg;
    logic       write_en_next;
    logic       bank_sel_reg;
    logic       inhibit_reg;

    // Result select: 1 when the RAM byte is returned.
    logic       sel_ram_reg;
    logic [DataW-1:0] rd_data_reg;

    // One memory holds both banks and the upper RAM.
    logic [DataW-1:0] mem [MemBytes];
    logic [MemIdxW-1:0]   mem_idx;
    logic [UpperIdxW-1:0] upper_idx;
    logic                 is_lower;
    logic                 odd_read;
    logic                 mem_rd;
    logic                 mem_wr;

    // Capture the accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            addr_reg  <= address;
            write_reg <= write;
            data_reg  <= data_in;
        end
    end

    // Map a region offset onto the memory: lower banks first, then upper RAM.
    always_comb
    begin
        is_lower  = (addr_reg < AddrW'(BankBytes));
        upper_idx = addr_reg[UpperIdxW-1:0] - LowerLimit;
        if (is_lower)
        begin
            mem_idx = {1'b0, ~bank_sel_reg, addr_reg[BankIdxW-1:0]};
        end
        else
        begin
            mem_idx = {1'b1, upper_idx};
        end
    end

    // Access decode for a memory-region transaction.
    assign mem_rd = cmd.exec && (func_reg == FuncMemory) && read_en_reg && !write_reg;
    assign mem_wr = cmd.exec && (func_reg == FuncMemory) && !(read_en_reg && !write_reg)
                    && write_en_reg && write_reg;

    // Soft-switch next values.
    always_comb
    begin
        odd_read = addr_reg[0] && !write_reg;
        if (!odd_read)
        begin
            odd_cnt_next = 2'd0;
        end
        else if (odd_cnt_reg >= OddReadMax)
        begin
            odd_cnt_next = OddReadMax;
        end
        else
        begin
            odd_cnt_next = odd_cnt_reg + 2'd1;
        end
        write_en_next = write_en_reg;
        if (odd_cnt_next >= OddReadMax)
        begin
            write_en_next = 1'b1;
        end
        if (!addr_reg[0])
        begin
            write_en_next = 1'b0;
        end
    end

    // Switch latches and the ROM-inhibit flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            odd_cnt_reg  <= 2'd0;
            read_en_reg  <= 1'b0;
            write_en_reg <= 1'b1;
            bank_sel_reg <= 1'b1;
            inhibit_reg  <= 1'b0;
        end
        else if (cmd.exec)
        begin
            if (func_reg == FuncSwitch)
            begin
                odd_cnt_reg  <= odd_cnt_next;
                write_en_reg <= write_en_next;
                read_en_reg  <= addr_reg[1:0] inside {2'b00, 2'b11};
                bank_sel_reg <= !addr_reg[3];
            end
            else
            begin
                inhibit_reg <= mem_rd;
            end
        end
    end

    // RAM port: one write or one registered read per transaction.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[mem_idx] <= data_reg;
        end
        if (mem_rd)
        begin
            rd_data_reg <= mem[mem_idx];
        end
    end

    // Result source select.
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            sel_ram_reg <= mem_rd;
        end
    end

    // Result fields, held stable until the controller leaves its response state.
    assign data_out    = sel_ram_reg ? rd_data_reg : data_reg;
    assign inhibit_rom = inhibit_reg;

endmodule

/* tb/bank_switched_ram_card_top_tb.sv */
// Self-checking testbench for the bank-switched 16K RAM card top level.
`timescale 1ns / 1ps

module bank_switched_ram_card_top_tb;
    import bsrc_pkg::*;

    // One result transaction as seen on the output channel.
    typedef struct packed {
        logic [DataW-1:0] data;
        logic             inhibit;
    } bus_result_t;

    localparam int WatchdogLimit = 2000;
    localparam int HoldOffCycles = 150;
    localparam int ReportLimit   = 10;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic             func        = FuncSwitch;
    logic [AddrW-1:0] address     = '0;
    logic             write       = 1'b0;
    logic [DataW-1:0] data_in     = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    logic [DataW-1:0] data_out;
    logic             inhibit_rom;

    // Idle rates in percent, and the request for a long receiver hold-off.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    bus_result_t pending_results[$];

    // Card state as the testbench predicts it.
    logic [1:0]       odd_reads;
    logic             rd_en;
    logic             wr_en;
    logic             bank_sel;
    logic             rom_inhibit;
    logic [DataW-1:0] bank_mem [2][BankBytes];
    bit               bank_seen [2][BankBytes];
    logic [DataW-1:0] upper_mem [UpperBytes];
    bit               upper_seen [UpperBytes];
    int               bank0_list[$];
    int               bank1_list[$];
    int               upper_list[$];

    bank_switched_ram_card_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .address     (address),
        .write       (write),
        .data_in     (data_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .inhibit_rom (inhibit_rom)
    );

    always #6 clk = ~clk;

    // Work out the result of one accepted bus access and advance the card state.
    function automatic bus_result_t predict_bus_result(input logic f,
                                                       input logic [AddrW-1:0] a,
                                                       input logic w,
                                                       input logic [DataW-1:0] d);
        bus_result_t res;
        logic [BankIdxW-1:0]  bidx;
        logic [UpperIdxW-1:0] uidx;
        logic                 lower;
        res.data = d;
        if (f == FuncSwitch)
        begin
            if (a[0] && !w)
            begin
                if (odd_reads < OddReadMax)
                    odd_reads = odd_reads + 2'd1;
            end
            else
                odd_reads = 2'd0;
            if (odd_reads == OddReadMax)
                wr_en = 1'b1;
            if (!a[0])
                wr_en = 1'b0;
            rd_en    = (a[1:0] == 2'b00) || (a[1:0] == 2'b11);
            bank_sel = !a[3];
        end
        else
        begin
            lower       = (a < BankBytes);
            bidx        = a[BankIdxW-1:0];
            uidx        = UpperIdxW'(a - BankBytes);
            rom_inhibit = 1'b0;
            if (rd_en && !w)
            begin
                res.data    = lower ? bank_mem[bank_sel][bidx] : upper_mem[uidx];
                rom_inhibit = 1'b1;
            end
            else if (wr_en && w)
            begin
                if (lower)
                begin
                    bank_mem[bank_sel][bidx] = d;
                    if (!bank_seen[bank_sel][bidx])
                    begin
                        bank_seen[bank_sel][bidx] = 1'b1;
                        if (bank_sel)
                            bank1_list = {bank1_list, int'(bidx)};
                        else
                            bank0_list = {bank0_list, int'(bidx)};
                    end
                end
                else
                begin
                    upper_mem[uidx] = d;
                    if (!upper_seen[uidx])
                    begin
                        upper_seen[uidx] = 1'b1;
                        upper_list = {upper_list, int'(uidx)};
                    end
                end
            end
        end
        res.inhibit = rom_inhibit;
        return res;
    endfunction

    // Return a region address that reads an already written location, or -1.
    function automatic int written_addr(input bit from_upper);
        int idx;
        int addr;
        if (from_upper)
        begin
            if (upper_list.size() == 0)
                return -1;
            idx  = upper_list[$urandom_range(upper_list.size() - 1)];
            addr = BankBytes + idx;
            // Offsets past the 12K window alias onto the upper RAM.
            if (idx < BankBytes && $urandom_range(1) == 1)
                addr += UpperBytes;
            return addr;
        end
        if (bank_sel)
        begin
            if (bank1_list.size() == 0)
                return -1;
            return bank1_list[$urandom_range(bank1_list.size() - 1)];
        end
        if (bank0_list.size() == 0)
            return -1;
        return bank0_list[$urandom_range(bank0_list.size() - 1)];
    endfunction

    // A served read must hit a written location; redirect it or turn it into a write.
    task automatic keep_reads_on_written(input logic f, inout logic [AddrW-1:0] a,
                                         inout logic w);
        logic [UpperIdxW-1:0] uidx;
        bit                   seen;
        int                   alt;
        if (f == FuncMemory && !w && rd_en)
        begin
            uidx = UpperIdxW'(a - BankBytes);
            seen = (a < BankBytes) ? bank_seen[bank_sel][a[BankIdxW-1:0]] : upper_seen[uidx];
            if (!seen)
            begin
                alt = written_addr(a >= BankBytes);
                if (alt < 0)
                    alt = written_addr(a < BankBytes);
                if (alt < 0)
                    w = 1'b1;
                else
                    a = AddrW'(alt);
            end
        end
    endtask

    // Offer one access transaction, wait for it to be taken, then log its result.
    task automatic send_access(input logic f, input logic [AddrW-1:0] a, input logic w,
                               input logic [DataW-1:0] d);
        logic [AddrW-1:0] addr_q;
        logic             wr_q;
        bus_result_t      res_q;
        addr_q = a;
        wr_q   = w;
        keep_reads_on_written(f, addr_q, wr_q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        address  <= addr_q;
        write    <= wr_q;
        data_in  <= d;
        do
            @(posedge clk);
        while (in_stall);
        res_q           = predict_bus_result(f, addr_q, wr_q, d);
        pending_results = {pending_results, res_q};
    endtask

    // Memory offsets: mostly small hot windows so that reads find written data.
    function automatic logic [AddrW-1:0] pick_mem_addr();
        case ($urandom_range(3))
            0: return AddrW'($urandom_range(63));
            1: return AddrW'(BankBytes + $urandom_range(63));
            2: return AddrW'(BankBytes + UpperBytes + $urandom_range(63));
            default: return AddrW'($urandom_range(16383));
        endcase
    endfunction

    // Receiver side: random stalls, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_request && hold_left == 0)
        begin
            hold_left    = HoldOffCycles;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic note_mismatch(input bus_result_t want, input bit have_want);
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
        begin
            if (have_want)
                $display("mismatch at %0t: expected %02h/%0b, got %02h/%0b (data/inhibit)",
                         $realtime, want.data, want.inhibit, data_out, inhibit_rom);
            else
                $display("mismatch at %0t: unexpected result %02h/%0b (data/inhibit)",
                         $realtime, data_out, inhibit_rom);
        end
    endtask

    // Compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        bus_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                note_mismatch('0, 1'b0);
            else
            begin
                want = pending_results.pop_front();
                if (data_out !== want.data || inhibit_rom !== want.inhibit)
                    note_mismatch(want, 1'b1);
            end
        end
    end

    // Watchdog on cycles without any accepted transaction or taken result.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WatchdogLimit)
        begin
            $display("bank_switched_ram_card_top regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Reset state, every switch pattern kind, wrap-around and passthrough cases.
    task automatic test_directed_cases();
        send_access(FuncMemory, 14'h0000, 1'b0, 8'h5A);  // read while reads are off
        send_access(FuncMemory, 14'h0000, 1'b1, 8'hFF);  // writes enabled after reset
        send_access(FuncMemory, 14'h3FFF, 1'b1, 8'h00);  // offset past the window wraps
        send_access(FuncMemory, 14'h2FFF, 1'b1, 8'h81);  // last upper byte
        send_access(FuncSwitch, 14'h0003, 1'b0, 8'hC3);  // one odd read, reads on
        send_access(FuncMemory, 14'h0000, 1'b0, 8'h00);
        send_access(FuncSwitch, 14'h3FF0, 1'b0, 8'h3C);  // even: writes off, inhibit kept
        send_access(FuncMemory, 14'h1FFF, 1'b0, 8'hAA);
        send_access(FuncMemory, 14'h2FFF, 1'b1, 8'h11);  // write dropped
        send_access(FuncMemory, 14'h2FFF, 1'b0, 8'h22);
        send_access(FuncSwitch, 14'h000B, 1'b0, 8'h01);  // bank 0, first odd read
        send_access(FuncSwitch, 14'h000B, 1'b0, 8'h02);  // second odd read enables writes
        send_access(FuncSwitch, 14'h000B, 1'b0, 8'h03);  // counter saturates
        send_access(FuncMemory, 14'h0123, 1'b1, 8'hA5);
        send_access(FuncMemory, 14'h0123, 1'b0, 8'h00);
        send_access(FuncSwitch, 14'h0009, 1'b1, 8'hFE);  // odd write clears the counter
        send_access(FuncMemory, 14'h0123, 1'b0, 8'h7E);  // reads off: passthrough
        send_access(FuncMemory, 14'h0FFF, 1'b1, 8'hFF);
        send_access(FuncSwitch, 14'h0001, 1'b0, 8'h10);
        send_access(FuncSwitch, 14'h0002, 1'b0, 8'h20);
        send_access(FuncSwitch, 14'h0003, 1'b0, 8'h30);
        send_access(FuncMemory, 14'h3FFF, 1'b0, 8'h40);
        send_access(FuncSwitch, 14'h0004, 1'b1, 8'h50);
    endtask

    // Switch setup sequences followed by bursts of memory accesses, with some noise.
    task automatic test_random_traffic(input int n_items);
        int               sent;
        int               reps;
        int               burst;
        logic [AddrW-1:0] sw;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_access(logic'($urandom_range(1)), AddrW'($urandom_range(16383)),
                            logic'($urandom_range(1)), DataW'($urandom_range(255)));
                sent++;
            end
            else
            begin
                sw   = AddrW'($urandom_range(16383));
                reps = ($urandom_range(3) == 0) ? 1 : 2;
                for (int k = 0; k < reps; k++)
                begin
                    send_access(FuncSwitch, sw, ($urandom_range(9) == 0),
                                DataW'($urandom_range(255)));
                    sent++;
                end
                burst = $urandom_range(1, 8);
                for (int k = 0; k < burst; k++)
                begin
                    send_access(FuncMemory, pick_mem_addr(), logic'($urandom_range(1)),
                                DataW'($urandom_range(255)));
                    sent++;
                end
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_receiver_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_request = 1'b1;
        @(posedge clk);
        for (int k = 0; k < 12; k++)
            send_access(FuncMemory, pick_mem_addr(), logic'($urandom_range(1)),
                        DataW'($urandom_range(255)));
    endtask

    initial
    begin
        odd_reads   = 2'd0;
        rd_en       = 1'b0;
        wr_en       = 1'b1;
        bank_sel    = 1'b1;
        rom_inhibit = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();

        send_idle_pct = 32;
        recv_idle_pct = 53;
        test_random_traffic(590);
        send_idle_pct = 53;
        recv_idle_pct = 32;
        test_random_traffic(590);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(590);

        test_receiver_hold_off();
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("bank_switched_ram_card_top regression: pass");
        else
            $display("bank_switched_ram_card_top regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/bsrc_pkg.sv
hdl/bsrc_ctrl.sv
hdl/bsrc_datapath.sv
hdl/bank_switched_ram_card_top.sv
tb/bank_switched_ram_card_top_tb.sv
